// ----- design/hpmd_pkg.sv -----
// Shared types and constants for the heat pump mode detector.
package hpmd_pkg;

	// Operating state of the controller
	typedef enum logic [2:0] {
		ST_STANDBY   = 3'd0,
		ST_STARTUP   = 3'd1,
		ST_HOT_WATER = 3'd2,
		ST_HEATING   = 3'd3,
		ST_COOLING   = 3'd4,
		ST_POST_RUN  = 3'd5
	} mode_t;

	// Pump control reported with each result
	typedef enum logic [1:0] {
		PM_NORMAL  = 2'd0,
		PM_DEFROST = 2'd1,
		PM_POSTRUN = 2'd2
	} pump_t;

	// Defrost event codes
	typedef enum logic [1:0] {
		DEV_NONE  = 2'd0,
		DEV_START = 2'd1,
		DEV_END   = 2'd2
	} dfr_evt_t;

	// Transition event codes
	typedef enum logic [3:0] {
		TEV_NONE        = 4'd0,
		TEV_STARTED     = 4'd1,
		TEV_STOPPED     = 4'd2,
		TEV_HOT_WATER   = 4'd3,
		TEV_COOLING     = 4'd4,
		TEV_HEATING     = 4'd5,
		TEV_HEAT_NOSENS = 4'd6,
		TEV_POSTRUN     = 4'd7,
		TEV_HW_TO_HEAT  = 4'd8,
		TEV_TO_HW       = 4'd9,
		TEV_RESTARTED   = 4'd10,
		TEV_POSTRUN_END = 4'd11
	} trans_evt_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_STARTUP_WAIT  = 3'd0,
		REG_POSTRUN       = 3'd1,
		REG_HOT_WATER     = 3'd2,
		REG_COOL_TREND    = 3'd3,
		REG_DFR_DUTY      = 3'd4,
		REG_DFR_INTERVAL  = 3'd5,
		REG_DFR_DROP      = 3'd6
	} reg_idx_t;

	// Field widths
	localparam int unsigned WaitW     = 22;
	localparam int unsigned PostW     = 23;
	localparam int unsigned TempW     = 12;
	localparam int unsigned TrendW    = 11;
	localparam int unsigned DutyW     = 10;
	localparam int unsigned IntervalW = 20;
	localparam int unsigned DropW     = 10;
	localparam int unsigned TimeW     = 32;
	localparam int unsigned CfgDataW  = 23;

	// Register reset values
	localparam logic [WaitW-1:0]     RstStartupWait = 22'd120000;
	localparam logic [PostW-1:0]     RstPostrun     = 23'd1800000;
	localparam logic [TempW-1:0]     RstHotWater    = 12'sd450;
	localparam logic [TrendW-1:0]    RstCoolTrend   = -11'sd10;
	localparam logic [DutyW-1:0]     RstDfrDuty     = 10'd900;
	localparam logic [IntervalW-1:0] RstDfrInterval = 20'd30000;
	localparam logic [DropW-1:0]     RstDfrDrop     = 10'd3;

endpackage

// ----- design/heat_pump_mode_detector.sv -----
// Heat pump mode detector: input register, state update and result register.
// A beat waits in the input register; its result is registered as the stage advances.
// Throughput: one beat per cycle; a result held by m_tready low stalls the input, and the
// controller state is updated in place between the input and result registers.
// Reset (arst_n low, asynchronous): standby, no defrost, all stamps and held
// temperatures cleared, configuration registers back to their defaults.
module heat_pump_mode_detector (
	input  logic        clk,
	input  logic        arst_n,
	// Input beat
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // pwm_active[0], duty[10:1], temperature[22:11], now_ms[54:23]
	input  logic        s_tuser,  // temp_valid[0]
	// Result beat
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // mode_state[2:0], pump_mode[4:3], defrosting[5],
	                              // defrost_event[7:6], transition_event[11:8],
	                              // remaining_ms[34:12]
	// Configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [hpmd_pkg::CfgDataW-1:0] cfg_data
);

	// Configuration registers
	logic [hpmd_pkg::WaitW-1:0]       startup_wait_q;
	logic [hpmd_pkg::PostW-1:0]       postrun_q;
	logic signed [hpmd_pkg::TempW-1:0]  hot_temp_q;
	logic signed [hpmd_pkg::TrendW-1:0] cool_trend_q;
	logic [hpmd_pkg::DutyW-1:0]       dfr_duty_q;
	logic [hpmd_pkg::IntervalW-1:0]   dfr_interval_q;
	logic [hpmd_pkg::DropW-1:0]       dfr_drop_q;

	// Input stage
	logic                               valid_s1;
	logic                               pwm_s1;
	logic [hpmd_pkg::DutyW-1:0]         duty_s1;
	logic signed [hpmd_pkg::TempW-1:0]  temp_s1;
	logic                               tv_s1;
	logic [hpmd_pkg::TimeW-1:0]         now_s1;

	// Controller state
	hpmd_pkg::mode_t                    mode_q;
	logic                               defrost_q;
	logic [hpmd_pkg::TimeW-1:0]         startup_stamp_q;
	logic [hpmd_pkg::TimeW-1:0]         postrun_stamp_q;
	logic signed [hpmd_pkg::TempW-1:0]  start_temp_q;
	logic                               start_held_q;
	logic signed [hpmd_pkg::TempW-1:0]  sample_temp_q;
	logic [hpmd_pkg::TimeW-1:0]         sample_stamp_q;
	logic                               sample_held_q;

	// Next-state values
	hpmd_pkg::mode_t                    mode_nx;
	logic                               defrost_nx;
	logic [hpmd_pkg::TimeW-1:0]         startup_stamp_nx;
	logic [hpmd_pkg::TimeW-1:0]         postrun_stamp_nx;
	logic signed [hpmd_pkg::TempW-1:0]  start_temp_nx;
	logic                               start_held_nx;
	logic                               start_held_cap;
	logic signed [hpmd_pkg::TempW-1:0]  sample_temp_nx;
	logic [hpmd_pkg::TimeW-1:0]         sample_stamp_nx;
	logic                               sample_held_nx;
	hpmd_pkg::dfr_evt_t                 dev_nx;
	hpmd_pkg::trans_evt_t               tev_nx;
	hpmd_pkg::pump_t                    pump_nx;
	logic [hpmd_pkg::PostW-1:0]         rem_nx;

	// Datapath helpers
	logic [hpmd_pkg::TimeW-1:0]         el_sample;
	logic [hpmd_pkg::TimeW-1:0]         el_start;
	logic [hpmd_pkg::TimeW-1:0]         el_start_nx;
	logic [hpmd_pkg::TimeW-1:0]         el_post_nx;
	logic [13:0]                        drop_sum;
	logic signed [12:0]                 trend;
	logic                               in_run;
	logic                               dfr_check;

	// Result register
	logic                               out_valid_q;
	hpmd_pkg::mode_t                    res_mode_q;
	hpmd_pkg::pump_t                    res_pump_q;
	logic                               res_dfr_q;
	hpmd_pkg::dfr_evt_t                 res_dev_q;
	hpmd_pkg::trans_evt_t               res_tev_q;
	logic [hpmd_pkg::PostW-1:0]         res_rem_q;

	logic                               advance;

	// Handshake: the stage moves when its result slot is free or being drained
	assign advance   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {5'd0, res_rem_q, res_tev_q, res_dev_q, res_dfr_q, res_pump_q, res_mode_q};

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			startup_wait_q <= hpmd_pkg::RstStartupWait;
			postrun_q      <= hpmd_pkg::RstPostrun;
			hot_temp_q     <= hpmd_pkg::RstHotWater;
			cool_trend_q   <= hpmd_pkg::RstCoolTrend;
			dfr_duty_q     <= hpmd_pkg::RstDfrDuty;
			dfr_interval_q <= hpmd_pkg::RstDfrInterval;
			dfr_drop_q     <= hpmd_pkg::RstDfrDrop;
		end else if (cfg_valid && cfg_ready) begin
			case (hpmd_pkg::reg_idx_t'(cfg_index))
				hpmd_pkg::REG_STARTUP_WAIT: startup_wait_q <= cfg_data[hpmd_pkg::WaitW-1:0];
				hpmd_pkg::REG_POSTRUN:      postrun_q      <= cfg_data[hpmd_pkg::PostW-1:0];
				hpmd_pkg::REG_HOT_WATER:    hot_temp_q     <= cfg_data[hpmd_pkg::TempW-1:0];
				hpmd_pkg::REG_COOL_TREND:   cool_trend_q   <= cfg_data[hpmd_pkg::TrendW-1:0];
				hpmd_pkg::REG_DFR_DUTY:     dfr_duty_q     <= cfg_data[hpmd_pkg::DutyW-1:0];
				hpmd_pkg::REG_DFR_INTERVAL: dfr_interval_q <= cfg_data[hpmd_pkg::IntervalW-1:0];
				hpmd_pkg::REG_DFR_DROP:     dfr_drop_q     <= cfg_data[hpmd_pkg::DropW-1:0];
				default: ;
			endcase
		end
	end

	// Capture the input beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			pwm_s1  <= s_tdata[0];
			duty_s1 <= s_tdata[10:1];
			temp_s1 <= s_tdata[22:11];
			tv_s1   <= s_tuser;
			now_s1  <= s_tdata[54:23];
		end
	end

	// Defrost detection from temperature drop per sampling interval
	assign in_run    = (mode_q inside {hpmd_pkg::ST_HOT_WATER, hpmd_pkg::ST_HEATING});
	assign dfr_check = (duty_s1 >= dfr_duty_q) && tv_s1;
	assign el_sample = now_s1 - sample_stamp_q;
	assign drop_sum  = {{2{temp_s1[11]}}, temp_s1} - {{2{sample_temp_q[11]}}, sample_temp_q}
	                 + {4'd0, dfr_drop_q};

	always_comb begin
		defrost_nx      = defrost_q;
		sample_temp_nx  = sample_temp_q;
		sample_stamp_nx = sample_stamp_q;
		sample_held_nx  = sample_held_q;
		dev_nx          = hpmd_pkg::DEV_NONE;
		if (in_run) begin
			if (dfr_check) begin
				if (sample_held_q && (el_sample >= {12'd0, dfr_interval_q})) begin
					defrost_nx      = drop_sum[13];
					sample_temp_nx  = temp_s1;
					sample_stamp_nx = now_s1;
				end else if (!sample_held_q) begin
					sample_temp_nx  = temp_s1;
					sample_stamp_nx = now_s1;
					sample_held_nx  = 1'b1;
				end
			end else begin
				defrost_nx = 1'b0;
			end
			if (defrost_nx != defrost_q) begin
				dev_nx = defrost_nx ? hpmd_pkg::DEV_START : hpmd_pkg::DEV_END;
			end
		end else if (defrost_q) begin
			defrost_nx = 1'b0;
			dev_nx     = hpmd_pkg::DEV_END;
		end
	end

	// Startup temperature capture and trend
	assign start_held_cap = start_held_q || tv_s1;
	assign start_temp_nx  = (!start_held_q && tv_s1) ? temp_s1 : start_temp_q;
	assign el_start       = now_s1 - startup_stamp_q;
	assign trend          = 13'(temp_s1) - 13'(start_temp_nx);

	// Next mode and transition event
	always_comb begin
		mode_nx          = mode_q;
		tev_nx           = hpmd_pkg::TEV_NONE;
		startup_stamp_nx = startup_stamp_q;
		postrun_stamp_nx = postrun_stamp_q;
		start_held_nx    = start_held_q;
		case (mode_q)
			hpmd_pkg::ST_STARTUP: begin
				if (!pwm_s1) begin
					mode_nx       = hpmd_pkg::ST_STANDBY;
					tev_nx        = hpmd_pkg::TEV_STOPPED;
					start_held_nx = 1'b0;
				end else if (el_start >= {10'd0, startup_wait_q}) begin
					if (tv_s1) begin
						if (temp_s1 > hot_temp_q) begin
							mode_nx = hpmd_pkg::ST_HOT_WATER;
							tev_nx  = hpmd_pkg::TEV_HOT_WATER;
						end else if (trend <= 13'(cool_trend_q)) begin
							mode_nx = hpmd_pkg::ST_COOLING;
							tev_nx  = hpmd_pkg::TEV_COOLING;
						end else begin
							mode_nx = hpmd_pkg::ST_HEATING;
							tev_nx  = hpmd_pkg::TEV_HEATING;
						end
					end else begin
						mode_nx = hpmd_pkg::ST_HEATING;
						tev_nx  = hpmd_pkg::TEV_HEAT_NOSENS;
					end
					start_held_nx = 1'b0;
				end else begin
					start_held_nx = start_held_cap;
				end
			end
			hpmd_pkg::ST_HOT_WATER, hpmd_pkg::ST_HEATING, hpmd_pkg::ST_COOLING: begin
				if (!pwm_s1) begin
					if (mode_q == hpmd_pkg::ST_HOT_WATER) begin
						mode_nx          = hpmd_pkg::ST_POST_RUN;
						tev_nx           = hpmd_pkg::TEV_POSTRUN;
						postrun_stamp_nx = now_s1;
					end else begin
						mode_nx = hpmd_pkg::ST_STANDBY;
						tev_nx  = hpmd_pkg::TEV_STOPPED;
					end
				end else if (tv_s1) begin
					if (mode_q == hpmd_pkg::ST_HOT_WATER) begin
						if (temp_s1 < hot_temp_q) begin
							mode_nx = hpmd_pkg::ST_HEATING;
							tev_nx  = hpmd_pkg::TEV_HW_TO_HEAT;
						end
					end else if (temp_s1 > hot_temp_q) begin
						mode_nx = hpmd_pkg::ST_HOT_WATER;
						tev_nx  = hpmd_pkg::TEV_TO_HW;
					end
				end
			end
			hpmd_pkg::ST_POST_RUN: begin
				if (pwm_s1) begin
					mode_nx          = hpmd_pkg::ST_STARTUP;
					tev_nx           = hpmd_pkg::TEV_RESTARTED;
					startup_stamp_nx = now_s1;
					start_held_nx    = 1'b0;
				end else if ((now_s1 - postrun_stamp_q) >= {9'd0, postrun_q}) begin
					mode_nx = hpmd_pkg::ST_STANDBY;
					tev_nx  = hpmd_pkg::TEV_POSTRUN_END;
				end
			end
			default: begin
				mode_nx = hpmd_pkg::ST_STANDBY;
				if (pwm_s1) begin
					mode_nx          = hpmd_pkg::ST_STARTUP;
					tev_nx           = hpmd_pkg::TEV_STARTED;
					startup_stamp_nx = now_s1;
					start_held_nx    = 1'b0;
				end
			end
		endcase
	end

	// Remaining time and pump mode after the update
	assign el_start_nx = now_s1 - startup_stamp_nx;
	assign el_post_nx  = now_s1 - postrun_stamp_nx;

	always_comb begin
		rem_nx  = '0;
		pump_nx = hpmd_pkg::PM_NORMAL;
		if (mode_nx == hpmd_pkg::ST_STARTUP) begin
			if (el_start_nx < {10'd0, startup_wait_q}) begin
				rem_nx = {1'b0, startup_wait_q - el_start_nx[hpmd_pkg::WaitW-1:0]};
			end
		end else if (mode_nx == hpmd_pkg::ST_POST_RUN) begin
			if (el_post_nx < {9'd0, postrun_q}) begin
				rem_nx = postrun_q - el_post_nx[hpmd_pkg::PostW-1:0];
			end
		end
		if (mode_nx == hpmd_pkg::ST_POST_RUN) begin
			pump_nx = hpmd_pkg::PM_POSTRUN;
		end else if (defrost_nx) begin
			pump_nx = hpmd_pkg::PM_DEFROST;
		end
	end

	// Update controller state as each beat is processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q          <= hpmd_pkg::ST_STANDBY;
			defrost_q       <= 1'b0;
			startup_stamp_q <= '0;
			postrun_stamp_q <= '0;
			start_temp_q    <= '0;
			start_held_q    <= 1'b0;
			sample_temp_q   <= '0;
			sample_stamp_q  <= '0;
			sample_held_q   <= 1'b0;
		end else if (advance) begin
			mode_q          <= mode_nx;
			defrost_q       <= defrost_nx;
			startup_stamp_q <= startup_stamp_nx;
			postrun_stamp_q <= postrun_stamp_nx;
			start_held_q    <= start_held_nx;
			sample_temp_q   <= sample_temp_nx;
			sample_stamp_q  <= sample_stamp_nx;
			sample_held_q   <= sample_held_nx;
			if (mode_q == hpmd_pkg::ST_STARTUP && pwm_s1) begin
				start_temp_q <= start_temp_nx;
			end
		end
	end

	// Hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_mode_q <= mode_nx;
			res_pump_q <= pump_nx;
			res_dfr_q  <= defrost_nx;
			res_dev_q  <= dev_nx;
			res_tev_q  <= tev_nx;
			res_rem_q  <= rem_nx;
		end
	end

`ifndef SYNTHESIS
	// Pump is forced exactly in post-run
	a_postrun_pump: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((res_pump_q == hpmd_pkg::PM_POSTRUN) == (res_mode_q == hpmd_pkg::ST_POST_RUN)))
		else $error("pump mode and post-run state disagree");

	// Defrost can only start from hot water or heating
	a_dfr_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(defrost_q) |-> ($past(mode_q) == hpmd_pkg::ST_HOT_WATER ||
		                      $past(mode_q) == hpmd_pkg::ST_HEATING))
		else $error("defrost set outside hot water or heating");

	// A stalled result freezes the controller state
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(mode_q) && $stable(defrost_q))
		else $error("state changed while the result was stalled");

	// Remaining time only in startup or post-run
	a_rem_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_rem_q != '0) |-> (res_mode_q == hpmd_pkg::ST_STARTUP ||
		                                    res_mode_q == hpmd_pkg::ST_POST_RUN))
		else $error("remaining time outside startup or post-run");
`endif

endmodule

// ----- tb/sv/heat_pump_mode_detector_tb.sv -----
// Self-checking testbench for the heat pump mode detector: directed rows, then random runs.
module heat_pump_mode_detector_tb;

	localparam int CycleLimit = 200000;

	// One update sample as it travels on s_tdata / s_tuser
	typedef struct packed {
		logic        pwm;
		logic [9:0]  duty;
		logic [11:0] temp;
		logic        tv;
		logic [31:0] now;
	} sample_t;

	// One result beat, field by field
	typedef struct packed {
		hpmd_pkg::mode_t      mode;
		hpmd_pkg::pump_t      pump;
		logic                 dfr;
		hpmd_pkg::dfr_evt_t   dev;
		hpmd_pkg::trans_evt_t tev;
		logic [22:0]          rem;
	} outcome_t;

	typedef struct packed {
		sample_t  s;
		logic     fixed;
		outcome_t want;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;   // pwm_active, duty, temperature, now_ms
	logic        s_tuser = 1'b0; // temp_valid
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;        // mode_state, pump_mode, defrosting, defrost_event,
	                             // transition_event, remaining_ms
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [22:0] cfg_data = '0;

	// Side information that travels with each input beat
	logic     row_fixed = 1'b0;
	outcome_t row_want = '0;

	heat_pump_mode_detector dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Predictor copy of the configuration
	logic [31:0] lim_wait     = 32'(hpmd_pkg::RstStartupWait);
	logic [31:0] lim_post     = 32'(hpmd_pkg::RstPostrun);
	int          lim_hw       = int'($signed(hpmd_pkg::RstHotWater));
	int          lim_trend    = int'($signed(hpmd_pkg::RstCoolTrend));
	logic [31:0] lim_duty     = 32'(hpmd_pkg::RstDfrDuty);
	logic [31:0] lim_interval = 32'(hpmd_pkg::RstDfrInterval);
	logic [31:0] lim_drop     = 32'(hpmd_pkg::RstDfrDrop);

	// Predictor copy of the controller state
	hpmd_pkg::mode_t cur_mode = hpmd_pkg::ST_STANDBY;
	logic        dfr_on     = 1'b0;
	logic [31:0] startup_t0 = '0;
	logic [31:0] postrun_t0 = '0;
	int          first_temp = 0;
	logic        first_held = 1'b0;
	int          probe_temp = 0;
	logic [31:0] probe_t0   = '0;
	logic        probe_held = 1'b0;

	outcome_t pending_outcomes[$];
	row_t     directed_rows[$];
	int       failures = 0;
	int       cycle_count = 0;

	// Stimulus shaping
	int          burst_left = 0;
	logic        calm = 1'b0;
	logic [31:0] clock_ms = '0;
	int          t_walk = 300;
	logic        pwm_level = 1'b0;

	// Receiver stall pattern
	logic [11:0] rx_pattern = '1;
	int          rx_tick = 0;

	// Apply one sample to the predicted state and return the result it yields
	function automatic outcome_t advance_detector(input sample_t s);
		outcome_t o;
		int t;
		logic [31:0] el;
		logic was;
		o = '0;
		t = int'($signed(s.temp));

		// Defrost detection runs on the state at the start of the step
		if (cur_mode == hpmd_pkg::ST_HOT_WATER || cur_mode == hpmd_pkg::ST_HEATING) begin
			was = dfr_on;
			if (s.duty >= lim_duty && s.tv) begin
				el = s.now - probe_t0;
				if (probe_held && el >= lim_interval) begin
					dfr_on = (t - probe_temp + int'(lim_drop)) < 0;
					probe_temp = t;
					probe_t0 = s.now;
				end else if (!probe_held) begin
					probe_temp = t;
					probe_t0 = s.now;
					probe_held = 1'b1;
				end
			end else begin
				dfr_on = 1'b0;
			end
			if (dfr_on != was)
				o.dev = dfr_on ? hpmd_pkg::DEV_START : hpmd_pkg::DEV_END;
		end else if (dfr_on) begin
			dfr_on = 1'b0;
			o.dev = hpmd_pkg::DEV_END;
		end

		// Mode transitions
		case (cur_mode)
			hpmd_pkg::ST_STARTUP: begin
				if (!s.pwm) begin
					cur_mode = hpmd_pkg::ST_STANDBY;
					o.tev = hpmd_pkg::TEV_STOPPED;
					first_held = 1'b0;
				end else begin
					if (!first_held && s.tv) begin
						first_temp = t;
						first_held = 1'b1;
					end
					el = s.now - startup_t0;
					if (el >= lim_wait) begin
						if (s.tv && first_held) begin
							if (t > lim_hw) begin
								cur_mode = hpmd_pkg::ST_HOT_WATER;
								o.tev = hpmd_pkg::TEV_HOT_WATER;
							end else if (t - first_temp <= lim_trend) begin
								cur_mode = hpmd_pkg::ST_COOLING;
								o.tev = hpmd_pkg::TEV_COOLING;
							end else begin
								cur_mode = hpmd_pkg::ST_HEATING;
								o.tev = hpmd_pkg::TEV_HEATING;
							end
						end else begin
							cur_mode = hpmd_pkg::ST_HEATING;
							o.tev = hpmd_pkg::TEV_HEAT_NOSENS;
						end
						first_held = 1'b0;
					end
				end
			end
			hpmd_pkg::ST_HOT_WATER, hpmd_pkg::ST_HEATING, hpmd_pkg::ST_COOLING: begin
				if (!s.pwm) begin
					if (cur_mode == hpmd_pkg::ST_HOT_WATER) begin
						cur_mode = hpmd_pkg::ST_POST_RUN;
						o.tev = hpmd_pkg::TEV_POSTRUN;
						postrun_t0 = s.now;
					end else begin
						cur_mode = hpmd_pkg::ST_STANDBY;
						o.tev = hpmd_pkg::TEV_STOPPED;
					end
				end else if (s.tv) begin
					if (cur_mode == hpmd_pkg::ST_HOT_WATER) begin
						if (t < lim_hw) begin
							cur_mode = hpmd_pkg::ST_HEATING;
							o.tev = hpmd_pkg::TEV_HW_TO_HEAT;
						end
					end else if (t > lim_hw) begin
						cur_mode = hpmd_pkg::ST_HOT_WATER;
						o.tev = hpmd_pkg::TEV_TO_HW;
					end
				end
			end
			hpmd_pkg::ST_POST_RUN: begin
				el = s.now - postrun_t0;
				if (s.pwm) begin
					cur_mode = hpmd_pkg::ST_STARTUP;
					o.tev = hpmd_pkg::TEV_RESTARTED;
					startup_t0 = s.now;
					first_held = 1'b0;
				end else if (el >= lim_post) begin
					cur_mode = hpmd_pkg::ST_STANDBY;
					o.tev = hpmd_pkg::TEV_POSTRUN_END;
				end
			end
			default: begin
				cur_mode = hpmd_pkg::ST_STANDBY;
				if (s.pwm) begin
					cur_mode = hpmd_pkg::ST_STARTUP;
					o.tev = hpmd_pkg::TEV_STARTED;
					startup_t0 = s.now;
					first_held = 1'b0;
				end
			end
		endcase

		// Remaining time of the running timer
		if (cur_mode == hpmd_pkg::ST_STARTUP) begin
			el = s.now - startup_t0;
			if (el < lim_wait)
				o.rem = 23'(lim_wait - el);
		end else if (cur_mode == hpmd_pkg::ST_POST_RUN) begin
			el = s.now - postrun_t0;
			if (el < lim_post)
				o.rem = 23'(lim_post - el);
		end

		if (cur_mode == hpmd_pkg::ST_POST_RUN)
			o.pump = hpmd_pkg::PM_POSTRUN;
		else if (dfr_on)
			o.pump = hpmd_pkg::PM_DEFROST;
		else
			o.pump = hpmd_pkg::PM_NORMAL;
		o.mode = cur_mode;
		o.dfr = dfr_on;
		return o;
	endfunction

	function automatic void check_field(input string name, input logic [22:0] want,
			input logic [22:0] got);
		if (got !== want) begin
			$error("%s expected %0d got %0d", name, want, got);
			failures++;
		end
	endfunction

	function automatic void plan(input logic pwm, input logic [9:0] duty,
			input logic [11:0] temp, input logic tv, input logic [31:0] now,
			input logic fixed, input outcome_t want);
		row_t r;
		r.s.pwm = pwm;
		r.s.duty = duty;
		r.s.temp = temp;
		r.s.tv = tv;
		r.s.now = now;
		r.fixed = fixed;
		r.want = want;
		directed_rows.push_back(r);
	endfunction

	// Track configuration writes, check result beats, predict accepted input beats
	always @(posedge clk) begin
		sample_t beat;
		outcome_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_outcomes.size() == 0) begin
					$error("result beat with no outcome pending: %h", m_tdata);
					failures++;
				end else begin
					want = pending_outcomes.pop_front();
					check_field("mode_state", want.mode, m_tdata[2:0]);
					check_field("pump_mode", want.pump, m_tdata[4:3]);
					check_field("defrosting", want.dfr, m_tdata[5]);
					check_field("defrost_event", want.dev, m_tdata[7:6]);
					check_field("transition_event", want.tev, m_tdata[11:8]);
					check_field("remaining_ms", want.rem, m_tdata[34:12]);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (hpmd_pkg::reg_idx_t'(cfg_index))
					hpmd_pkg::REG_STARTUP_WAIT: lim_wait = 32'(cfg_data[21:0]);
					hpmd_pkg::REG_POSTRUN:      lim_post = 32'(cfg_data[22:0]);
					hpmd_pkg::REG_HOT_WATER:    lim_hw = int'($signed(cfg_data[11:0]));
					hpmd_pkg::REG_COOL_TREND:   lim_trend = int'($signed(cfg_data[10:0]));
					hpmd_pkg::REG_DFR_DUTY:     lim_duty = 32'(cfg_data[9:0]);
					hpmd_pkg::REG_DFR_INTERVAL: lim_interval = 32'(cfg_data[19:0]);
					hpmd_pkg::REG_DFR_DROP:     lim_drop = 32'(cfg_data[9:0]);
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				beat.pwm = s_tdata[0];
				beat.duty = s_tdata[10:1];
				beat.temp = s_tdata[22:11];
				beat.now = s_tdata[54:23];
				beat.tv = s_tuser;
				want = advance_detector(beat);
				pending_outcomes.push_back(row_fixed ? row_want : want);
			end
		end
	end

	// Stall the result side on a pattern that is reloaded now and then
	always @(posedge clk) begin
		if (rx_tick % 40 == 0) begin
			if ($urandom_range(0, 2) == 0)
				rx_pattern = '1;
			else
				rx_pattern = 12'($urandom) | 12'h001;
		end
		m_tready <= rx_pattern[rx_tick % 12];
		rx_tick++;
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Drive one input beat, with a gap before it when a burst has run out and calm is not set
	task automatic send_sample(input sample_t s, input logic fixed, input outcome_t want);
		int gap;
		if (burst_left == 0) begin
			gap = calm ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 16);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, s.now, s.temp, s.duty, s.pwm};
		s_tuser <= s.tv;
		row_fixed <= fixed;
		row_want <= want;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Hold off input until every pending result has come back, then let the pipe drain
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_outcomes.size() != 0);
		repeat (6) @(posedge clk);
	endtask

	task automatic load_settings(input int wait_v, input int post_v, input int hw_v,
			input int trend_v, input int duty_v, input int intv_v, input int drop_v);
		logic [22:0] vals [7];
		int i;
		settle();
		vals[hpmd_pkg::REG_STARTUP_WAIT] = 23'(wait_v[21:0]);
		vals[hpmd_pkg::REG_POSTRUN] = post_v[22:0];
		vals[hpmd_pkg::REG_HOT_WATER] = 23'(hw_v[11:0]);
		vals[hpmd_pkg::REG_COOL_TREND] = 23'(trend_v[10:0]);
		vals[hpmd_pkg::REG_DFR_DUTY] = 23'(duty_v[9:0]);
		vals[hpmd_pkg::REG_DFR_INTERVAL] = 23'(intv_v[19:0]);
		vals[hpmd_pkg::REG_DFR_DROP] = 23'(drop_v[9:0]);
		for (i = hpmd_pkg::REG_STARTUP_WAIT; i <= hpmd_pkg::REG_DFR_DROP; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= hpmd_pkg::reg_idx_t'(i);
			cfg_data <= vals[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	// Mostly plausible operating sequences: sticky PWM, advancing time, drifting temperature
	task automatic run_phase(input int count);
		sample_t s;
		int span;
		int n;
		span = int'(lim_wait);
		if (int'(lim_post) > span)
			span = int'(lim_post);
		if (int'(lim_interval) > span)
			span = int'(lim_interval);
		span = span / 3 + 2;
		for (n = 0; n < count; n++) begin
			if ($urandom_range(0, 9) == 0) begin
				// noise beat: every field at random
				s.pwm = 1'($urandom);
				s.duty = 10'($urandom);
				s.temp = 12'($urandom);
				s.tv = 1'($urandom);
				s.now = $urandom;
			end else begin
				if ($urandom_range(0, 11) == 0)
					pwm_level = !pwm_level;
				case ($urandom_range(0, 19))
					0:       clock_ms += $urandom;
					1, 2:    ;
					default: clock_ms += $urandom_range(0, span);
				endcase
				if ($urandom_range(0, 15) == 0)
					t_walk = lim_hw + int'($urandom_range(0, 80)) - 40;
				else if ($urandom_range(0, 11) == 0)
					t_walk -= int'($urandom_range(0, 60));
				else
					t_walk += int'($urandom_range(0, 10)) - 6;
				if (t_walk > 2047)
					t_walk = 2047;
				if (t_walk < -2048)
					t_walk = -2048;
				s.pwm = pwm_level;
				if ($urandom_range(0, 9) < 7)
					s.duty = 10'($urandom_range(lim_duty, 1023));
				else
					s.duty = 10'($urandom_range(0, 1000));
				s.temp = t_walk[11:0];
				s.tv = ($urandom_range(0, 9) != 0);
				s.now = clock_ms;
			end
			send_sample(s, 1'b0, '0);
		end
	endtask

	initial begin
		// Directed rows under the reset configuration
		plan(1'b0, 10'd0, -12'sd550, 1'b0, 32'h0000_0000, 1'b1,
			'{hpmd_pkg::ST_STANDBY, hpmd_pkg::PM_NORMAL, 1'b0, hpmd_pkg::DEV_NONE,
			  hpmd_pkg::TEV_NONE, 23'd0});
		plan(1'b1, 10'd1000, 12'd1250, 1'b1, 32'hFFFF_FF00, 1'b1,
			'{hpmd_pkg::ST_STARTUP, hpmd_pkg::PM_NORMAL, 1'b0, hpmd_pkg::DEV_NONE,
			  hpmd_pkg::TEV_STARTED, 23'd120000});
		// first temperature across the time wrap, then cooling by trend
		plan(1'b1, 10'd1023, 12'd300, 1'b1, 32'h0000_1000, 1'b0, '0);
		plan(1'b1, 10'd0, 12'd290, 1'b1, 32'h0001_D3C0, 1'b0, '0);
		plan(1'b1, 10'd0, 12'd500, 1'b1, 32'h0001_D3C1, 1'b0, '0);
		// defrost sample, drop after one interval, hot water to heating
		plan(1'b1, 10'd1000, 12'd500, 1'b1, 32'h0001_D3C2, 1'b0, '0);
		plan(1'b1, 10'd950, 12'd490, 1'b1, 32'h0002_48F2, 1'b0, '0);
		plan(1'b1, 10'd950, 12'd400, 1'b1, 32'h0002_48F3, 1'b0, '0);
		// leave heating with defrost still set, cleared on the next step
		plan(1'b0, 10'd1000, 12'd400, 1'b1, 32'h0002_48F4, 1'b0, '0);
		plan(1'b0, 10'd0, 12'd0, 1'b0, 32'h0002_48F5, 1'b1,
			'{hpmd_pkg::ST_STANDBY, hpmd_pkg::PM_NORMAL, 1'b0, hpmd_pkg::DEV_END,
			  hpmd_pkg::TEV_NONE, 23'd0});
		// heating without a sensor, then hot water and post-run
		plan(1'b1, 10'd0, 12'd0, 1'b0, 32'h0010_0000, 1'b0, '0);
		plan(1'b1, 10'd0, 12'h800, 1'b0, 32'h0011_D4C0, 1'b0, '0);
		plan(1'b1, 10'd1000, 12'h7FF, 1'b1, 32'h0011_D4C1, 1'b0, '0);
		plan(1'b0, 10'd0, 12'd0, 1'b1, 32'h0011_D4C2, 1'b0, '0);
		plan(1'b0, 10'd0, 12'd0, 1'b1, 32'h002D_4C01, 1'b0, '0);
		// restart from post-run, stop in startup
		plan(1'b1, 10'd0, 12'd0, 1'b1, 32'h002D_4C02, 1'b0, '0);
		plan(1'b0, 10'd0, 12'd0, 1'b1, 32'h002D_4C03, 1'b0, '0);
		// heating by trend
		plan(1'b1, 10'd0, 12'd100, 1'b1, 32'h0040_0000, 1'b0, '0);
		plan(1'b1, 10'd0, 12'd100, 1'b1, 32'h0040_0001, 1'b0, '0);
		plan(1'b1, 10'd0, 12'd200, 1'b1, 32'h0041_D4C0, 1'b0, '0);
		plan(1'b0, 10'd0, 12'd0, 1'b0, 32'h0041_D4C1, 1'b0, '0);
		// hot water straight from startup, post-run runs out
		plan(1'b1, 10'd0, 12'd1250, 1'b1, 32'h0050_0000, 1'b0, '0);
		plan(1'b1, 10'd0, 12'd1250, 1'b1, 32'h0051_D4C0, 1'b0, '0);
		plan(1'b0, 10'd0, 12'd0, 1'b0, 32'h0051_D4C1, 1'b0, '0);
		plan(1'b0, 10'd0, 12'd0, 1'b0, 32'h006D_4C01, 1'b1,
			'{hpmd_pkg::ST_STANDBY, hpmd_pkg::PM_NORMAL, 1'b0, hpmd_pkg::DEV_NONE,
			  hpmd_pkg::TEV_POSTRUN_END, 23'd0});

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_sample(directed_rows[i].s, directed_rows[i].fixed, directed_rows[i].want);

		clock_ms = $urandom;
		run_phase(130);

		// Upper ends of the ranges, without gaps on the input side
		load_settings(3600000, 7200000, 1250, 1000, 1000, 600000, 1000);
		calm = 1'b1;
		run_phase(130);

		// Zero times and lower ends
		load_settings(0, 0, -550, -1000, 0, 0, 0);
		calm = 1'b0;
		run_phase(130);

		// Full field widths
		load_settings(4194303, 8388607, -2048, 1023, 1023, 1048575, 1023);
		run_phase(130);

		repeat (2) begin
			load_settings($urandom_range(0, 5000), $urandom_range(0, 5000),
				int'($urandom_range(0, 650)) - 100, int'($urandom_range(0, 70)) - 50,
				$urandom_range(0, 1000), $urandom_range(1, 3000), $urandom_range(0, 20));
			calm = 1'($urandom);
			run_phase(130);
		end

		load_settings(2000, 3000, 450, -10, 900, 500, 3);
		calm = 1'b0;
		run_phase(130);

		settle();
		if (failures == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
